>>> hdl/bmf_pkg.sv
// Shared constants and helpers for the box mean filter.
package bmf_pkg;

    localparam int MaxWidthDef  = 1024;
    localparam int MaxKernelDef = 15;

    // Register indexes of the configuration port
    localparam logic [1:0] CfgFrameWidth  = 2'd0;
    localparam logic [1:0] CfgFrameHeight = 2'd1;
    localparam logic [1:0] CfgKernelReq   = 2'd2;

    // Requested size to odd window size: small values give 3,
    // others drop to odd, then limited to the cap
    function automatic logic [3:0] snap_kernel(input logic [3:0] v, input logic [3:0] cap);
        logic [3:0] k;
        if (v < 4'd5) begin
            k = 4'd3;
        end else if (v[0]) begin
            k = v;
        end else begin
            k = v - 4'd1;
        end
        if (k > cap) begin
            k = cap;
        end
        return k;
    endfunction

    // 2^24 / (k*k) rounded up; bits [31:24] of sum * recip give the exact
    // truncated mean for every window sum up to k*k*255
    function automatic logic [20:0] kk_recip(input logic [3:0] k);
        logic [20:0] m;
        unique case (k)
            4'd3:    m = 21'd1864136;
            4'd5:    m = 21'd671089;
            4'd7:    m = 21'd342393;
            4'd9:    m = 21'd207127;
            4'd11:   m = 21'd138655;
            4'd13:   m = 21'd99274;
            4'd15:   m = 21'd74566;
            default: m = 21'd1864136;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/box_mean_filter_zero_pad.sv
// Top level of the zero-padded k-by-k box mean filter.
//
// Pixels arrive on the s_axis channel in raster order (tdata = pixel,
// tuser = filler flag); results leave on m_axis (tdata = mean, tlast on the
// frame's final pixel). Frame width, height and requested window size are
// written over the cfg channel between frames and latched at each frame's
// first word. Rows are kept in a ring of line buffers in one synchronous RAM.
// Each word passes through latch, setup and write states for write and
// bookkeeping; a word that produces a result adds k*k RAM reads (one per
// cycle, from the single read port), a state that settles the last read, one
// that scales the sum by the reciprocal of k*k and one that hands it over.
// Results lag the input by k/2 rows plus k/2 columns; after the last pixel,
// filler words drain the remaining results.
// A finished result sits in the output register while the next word is
// taken; if the receiver stalls, the block waits only when a second result
// is ready. Reset returns all counters to the start of a frame and the
// registers to 640 x 480 with k = 3. RAM contents need no clearing: every
// entry read has been written earlier in the same frame.
module box_mean_filter_zero_pad #(
    parameter int MAX_WIDTH  = bmf_pkg::MaxWidthDef,
    parameter int MAX_KERNEL = bmf_pkg::MaxKernelDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_pixel
    input  logic        s_axis_tuser,   // [0] in_filler
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_pixel
    output logic        m_axis_tlast
);

    localparam int KernelCap = MAX_KERNEL - 1 + (MAX_KERNEL % 2);
    localparam int RowSlots  = KernelCap + 1;
    localparam int SlotW     = $clog2(RowSlots);
    localparam int ColW      = $clog2(MAX_WIDTH);
    localparam int AddrW     = SlotW + ColW;
    localparam int Depth     = RowSlots << ColW;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LATCH = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_WRITE = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_ACC   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [10:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [3:0]  r_kernel_req;

    // per-frame latched settings
    logic [10:0] r_cur_w;
    logic [12:0] r_cur_h;
    logic [3:0]  r_cur_k;
    logic [2:0]  w_half;
    logic [22:0] r_total;
    logic [14:0] r_lag;
    logic [20:0] r_recip;

    // positions
    logic [10:0]      r_in_col, r_out_col;
    logic [12:0]      r_in_row, r_out_row;
    logic [SlotW-1:0] r_in_slot, r_out_slot, r_rd_slot;
    logic [23:0]      r_item_pos;
    logic [22:0]      r_out_count;
    logic [7:0]       r_pix;

    // window walk
    logic signed [4:0] r_dr, r_dc;
    logic signed [4:0] w_half_s;
    logic [15:0]       r_sum;
    logic              r_rd_en;

    // reciprocal scaling
    logic [15:0] r_quo;
    logic [31:0] w_prod;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_pixel;
    logic       r_out_last;

    // line store
    logic [7:0]       r_mem [Depth];
    logic [7:0]       r_mem_q;
    logic             w_mem_we;
    logic [AddrW-1:0] w_wr_addr, w_rd_addr;

    logic signed [14:0] w_rr;
    logic signed [12:0] w_cc;
    logic               w_in_range;
    logic [SlotW:0]     w_start_slot;
    logic               w_in_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pixel;
    assign m_axis_tlast  = r_out_last;

    assign w_half   = r_cur_k[3:1];
    assign w_half_s = $signed({2'b00, w_half});

    // window coordinates of the current read
    assign w_rr = $signed({2'b00, r_out_row}) + 15'(r_dr);
    assign w_cc = $signed({2'b00, r_out_col}) + 13'(r_dc);
    assign w_in_range = (w_rr >= 0) && (w_rr < $signed({2'b00, r_cur_h}))
                     && (w_cc >= 0) && (w_cc < $signed({2'b00, r_cur_w}));

    assign w_wr_addr = {r_in_slot, ColW'(r_in_col)};
    assign w_rd_addr = {r_rd_slot, ColW'(w_cc)};
    assign w_mem_we  = (r_state == S_WRITE) && ({1'b0, r_item_pos} < {2'b00, r_total});

    // first ring slot of the window, out_slot - half wrapped
    always_comb begin
        w_start_slot = {1'b0, r_out_slot} + (SlotW + 1)'(RowSlots) - (SlotW + 1)'(w_half);
        if (w_start_slot >= (SlotW + 1)'(RowSlots)) begin
            w_start_slot = w_start_slot - (SlotW + 1)'(RowSlots);
        end
    end

    // window sum times 2^24 / (k*k); the mean is in bits [31:24]
    assign w_prod = {16'd0, r_quo} * {11'd0, r_recip};

    // line store RAM
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= r_pix;
        end
        r_mem_q <= r_mem[w_rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_accept) n_state = S_LATCH;
            S_LATCH: n_state = S_SETUP;
            S_SETUP: n_state = S_WRITE;
            S_WRITE: n_state = (r_item_pos >= {9'd0, r_lag}) ? S_READ : S_IDLE;
            S_READ:  if (r_dr == w_half_s && r_dc == w_half_s) n_state = S_ACC;
            S_ACC:   n_state = S_DIV;
            S_DIV:   n_state = S_OUT;
            S_OUT:   if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 13'd480;
            r_kernel_req   <= 4'd0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bmf_pkg::CfgFrameWidth) begin
                r_frame_width <= i_cfg_data[10:0];
            end else if (i_cfg_index == bmf_pkg::CfgFrameHeight) begin
                r_frame_height <= i_cfg_data;
            end else if (i_cfg_index == bmf_pkg::CfgKernelReq) begin
                r_kernel_req <= i_cfg_data[3:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || m_axis_tready)) begin
            r_out_pixel <= r_quo[7:0];
            r_out_last  <= ({1'b0, r_out_count} + 24'd1 >= {1'b0, r_total});
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_w     <= 11'd640;
            r_cur_h     <= 13'd480;
            r_cur_k     <= 4'd3;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_slot   <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_slot  <= '0;
            r_out_count <= '0;
            r_item_pos  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_pix <= s_axis_tuser ? 8'd0 : s_axis_tdata;
                    end
                end
                S_LATCH: begin
                    // settings of a new frame
                    if (r_item_pos == '0) begin
                        if (r_frame_width == '0) begin
                            r_cur_w <= 11'd1;
                        end else if (32'(r_frame_width) > MAX_WIDTH) begin
                            r_cur_w <= 11'(MAX_WIDTH);
                        end else begin
                            r_cur_w <= r_frame_width;
                        end
                        r_cur_h <= (r_frame_height == '0) ? 13'd1 : r_frame_height;
                        r_cur_k <= bmf_pkg::snap_kernel(r_kernel_req, 4'(KernelCap));
                    end
                end
                S_SETUP: begin
                    r_total <= 23'(r_cur_w) * 23'(r_cur_h);
                    r_recip <= bmf_pkg::kk_recip(r_cur_k);
                    r_lag   <= 15'(w_half) * 15'(r_cur_w)
                             + ((11'(w_half) < r_cur_w - 11'd1) ? 15'(w_half)
                                                                : 15'(r_cur_w - 11'd1));
                end
                S_WRITE: begin
                    if (w_mem_we) begin
                        if (r_in_col + 11'd1 >= r_cur_w) begin
                            r_in_col <= '0;
                            r_in_row <= r_in_row + 13'd1;
                            r_in_slot <= (r_in_slot == SlotW'(RowSlots - 1)) ? '0
                                       : r_in_slot + SlotW'(1);
                        end else begin
                            r_in_col <= r_in_col + 11'd1;
                        end
                    end
                    if (r_item_pos < {9'd0, r_lag}) begin
                        r_item_pos <= r_item_pos + 24'd1;
                    end
                    // window walk setup
                    r_dr      <= -w_half_s;
                    r_dc      <= -w_half_s;
                    r_rd_slot <= w_start_slot[SlotW-1:0];
                    r_sum     <= '0;
                    r_rd_en   <= 1'b0;
                end
                S_READ: begin
                    if (r_rd_en) begin
                        r_sum <= r_sum + {8'd0, r_mem_q};
                    end
                    r_rd_en <= w_in_range;
                    if (r_dc == w_half_s) begin
                        r_dc <= -w_half_s;
                        r_dr <= r_dr + 5'sd1;
                        r_rd_slot <= (r_rd_slot == SlotW'(RowSlots - 1)) ? '0
                                   : r_rd_slot + SlotW'(1);
                    end else begin
                        r_dc <= r_dc + 5'sd1;
                    end
                end
                S_ACC: begin
                    r_quo <= r_sum + (r_rd_en ? {8'd0, r_mem_q} : 16'd0);
                end
                S_DIV: begin
                    // truncated mean from the scaled sum
                    r_quo <= {8'd0, w_prod[31:24]};
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        if ({1'b0, r_out_count} + 24'd1 >= {1'b0, r_total}) begin
                            // frame done: back to start
                            r_in_col    <= '0;
                            r_in_row    <= '0;
                            r_in_slot   <= '0;
                            r_out_col   <= '0;
                            r_out_row   <= '0;
                            r_out_slot  <= '0;
                            r_out_count <= '0;
                            r_item_pos  <= '0;
                        end else begin
                            r_out_count <= r_out_count + 23'd1;
                            r_item_pos  <= r_item_pos + 24'd1;
                            if (r_out_col + 11'd1 >= r_cur_w) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + 13'd1;
                                r_out_slot <= (r_out_slot == SlotW'(RowSlots - 1)) ? '0
                                            : r_out_slot + SlotW'(1);
                            end else begin
                                r_out_col <= r_out_col + 11'd1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
